/* hw/rtl/nqsc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nqsc_pkg
// shared types and constants of the n-queens subtree counter
// ----------------------------------------------------------------------------
package nqsc_pkg;

    localparam int COL_W     = 5;
    localparam int MASK_W    = 32;
    localparam int CFG_W     = 6;
    localparam int CNT_W     = 64;
    localparam int CFG_IDX_W = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BOARD_SIZE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_DEPTH = 1'b1;

    localparam logic [CFG_W-1:0] BOARD_SIZE_RST   = 6'd8;
    localparam logic [CFG_W-1:0] PREFIX_DEPTH_RST = 6'd0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_CAND,
        ST_UNDO,
        ST_CHK_RD,
        ST_CHK,
        ST_LEGAL,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

/* hw/rtl/nqsc_in_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nqsc_in_if
// prefix item channel: one prefix row per transfer
// ----------------------------------------------------------------------------
interface nqsc_in_if;
    import nqsc_pkg::*;

    logic             valid;
    logic             ready;
    logic [COL_W-1:0]  prefix_column;
    logic             column_present;
    logic [MASK_W-1:0] used_columns;
    logic             last_item;

    modport source (output valid, prefix_column, column_present, used_columns, last_item,
                    input ready);
    modport sink   (input valid, prefix_column, column_present, used_columns, last_item,
                    output ready);
endinterface
`default_nettype wire

/* hw/rtl/nqsc_out_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nqsc_out_if
// result channel: solution and node counts of one search
// ----------------------------------------------------------------------------
interface nqsc_out_if;
    import nqsc_pkg::*;

    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] solution_count;
    logic [CNT_W-1:0] visited_nodes;

    modport source (output valid, solution_count, visited_nodes, input ready);
    modport sink   (input valid, solution_count, visited_nodes, output ready);
endinterface
`default_nettype wire

/* hw/rtl/nqueens_subtree_counter.sv */
`default_nettype none
// search steps: data dependent; setup, then per candidate column a candidate step plus a read
//   and a compare per earlier row checked, a legal step per legal node, an undo per backtrack
// throughput: one search at a time, set by the single compare unit and one-read-port row store
// input is taken one prefix row per cycle while idle; the result is held until transferred
// reset: synchronous active low, config and counts to defaults, all rows empty, loading at row 0
// ----------------------------------------------------------------------------
// nqueens_subtree_counter
// loads a partial n-queens placement and counts all legal nodes and complete
// solutions below it by depth-first backtracking with an iterative checker
// ----------------------------------------------------------------------------
module nqueens_subtree_counter #(
    parameter int MAX_BOARD = 32
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire [nqsc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [nqsc_pkg::CFG_W-1:0]        i_cfg_data,
    nqsc_in_if.sink                          i_item,
    nqsc_out_if.source                       o_result
);
    import nqsc_pkg::*;

    localparam int RW = $clog2(MAX_BOARD);

    t_state               r_state, n_state;
    logic [CFG_W-1:0]     r_board, r_prefix;
    logic [RW:0]          r_loaded, n_loaded;
    logic [MAX_BOARD-1:0] r_rvalid, n_rvalid;
    logic [MASK_W-1:0]    r_mask, n_mask;
    logic [RW-1:0]        r_depth, n_depth;
    logic [RW-1:0]        r_p, n_p;
    logic [CFG_W-1:0]     r_n, n_n;
    logic [COL_W-1:0]     r_col, n_col;
    logic                 r_cur_valid, n_cur_valid;
    logic [RW-1:0]        r_idx, n_idx;
    logic                 r_rd_valid, n_rd_valid;
    logic [CNT_W-1:0]     r_sol, n_sol;
    logic [CNT_W-1:0]     r_nodes, n_nodes;

    logic [COL_W-1:0]     mem [MAX_BOARD];
    logic [COL_W-1:0]     r_rd_data;
    logic                 w_we, w_re;
    logic [RW-1:0]        w_waddr, w_raddr;
    logic [COL_W-1:0]     w_wdata;

    logic [CFG_W-1:0]     w_neff;
    logic [CFG_W-1:0]     w_cand;
    logic [RW-1:0]        w_dist;
    logic [6:0]           w_other7, w_col7, w_dist7;
    logic                 w_conflict;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    endfunction

    assign i_item.ready            = (r_state == ST_IDLE);
    assign o_result.valid          = (r_state == ST_DONE);
    assign o_result.solution_count = r_sol;
    assign o_result.visited_nodes  = r_nodes;

    assign w_neff   = (r_board > CFG_W'(MAX_BOARD)) ? CFG_W'(MAX_BOARD) : r_board;
    assign w_cand   = r_cur_valid ? (CFG_W'(r_col) + CFG_W'(1)) : '0;
    assign w_dist   = r_depth - r_idx;
    assign w_other7 = 7'(r_rd_data);
    assign w_col7   = 7'(r_col);
    assign w_dist7  = 7'(w_dist);
    assign w_conflict = r_rd_valid && ((w_other7 == w_col7) ||
                                       (w_other7 + w_dist7 == w_col7) ||
                                       (w_col7 + w_dist7 == w_other7));

    // row store
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_data <= mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_board  <= BOARD_SIZE_RST;
            r_prefix <= PREFIX_DEPTH_RST;
            r_loaded <= '0;
            r_rvalid <= '0;
            r_sol    <= '0;
            r_nodes  <= '0;
        end else begin
            r_state  <= n_state;
            r_loaded <= n_loaded;
            r_rvalid <= n_rvalid;
            r_sol    <= n_sol;
            r_nodes  <= n_nodes;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BOARD_SIZE:   r_board  <= i_cfg_data;
                    CFG_PREFIX_DEPTH: r_prefix <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mask      <= n_mask;
        r_depth     <= n_depth;
        r_p         <= n_p;
        r_n         <= n_n;
        r_col       <= n_col;
        r_cur_valid <= n_cur_valid;
        r_idx       <= n_idx;
        r_rd_valid  <= n_rd_valid;
    end

    always_comb begin
        n_state     = r_state;
        n_loaded    = r_loaded;
        n_rvalid    = r_rvalid;
        n_mask      = r_mask;
        n_depth     = r_depth;
        n_p         = r_p;
        n_n         = r_n;
        n_col       = r_col;
        n_cur_valid = r_cur_valid;
        n_idx       = r_idx;
        n_rd_valid  = r_rd_valid;
        n_sol       = r_sol;
        n_nodes     = r_nodes;
        w_we        = 1'b0;
        w_waddr     = r_depth;
        w_wdata     = r_col;
        w_re        = 1'b0;
        w_raddr     = r_idx;

        case (r_state)
            ST_IDLE: begin
                if (i_item.valid) begin
                    if (r_loaded < (RW+1)'(MAX_BOARD)) begin
                        w_we     = 1'b1;
                        w_waddr  = r_loaded[RW-1:0];
                        w_wdata  = i_item.column_present ? i_item.prefix_column : '0;
                        n_rvalid[r_loaded[RW-1:0]] = i_item.column_present;
                        n_loaded = r_loaded + (RW+1)'(1);
                    end
                    if (i_item.last_item) begin
                        n_mask  = i_item.used_columns;
                        n_state = ST_START;
                    end
                end
            end
            ST_START: begin
                n_sol   = '0;
                n_nodes = '0;
                if (r_prefix >= w_neff) begin
                    n_state = ST_DONE;
                end else begin
                    n_n         = w_neff;
                    n_p         = r_prefix[RW-1:0];
                    n_depth     = r_prefix[RW-1:0];
                    n_cur_valid = 1'b0;
                    for (int k = 0; k < MAX_BOARD; k++) begin
                        if (k >= int'(r_prefix)) begin
                            n_rvalid[k] = 1'b0;
                        end
                    end
                    n_state = ST_CAND;
                end
            end
            ST_CAND: begin
                if (w_cand >= r_n) begin
                    n_rvalid[r_depth] = 1'b0;
                    if (r_depth == r_p) begin
                        n_state = ST_DONE;
                    end else begin
                        n_depth = r_depth - RW'(1);
                        w_re    = 1'b1;
                        w_raddr = r_depth - RW'(1);
                        n_state = ST_UNDO;
                    end
                end else begin
                    w_we        = 1'b1;
                    w_waddr     = r_depth;
                    w_wdata     = w_cand[COL_W-1:0];
                    n_rvalid[r_depth] = 1'b1;
                    n_col       = w_cand[COL_W-1:0];
                    n_cur_valid = 1'b1;
                    if (r_mask[w_cand[COL_W-1:0]]) begin
                        n_state = ST_CAND;
                    end else if (r_depth == '0) begin
                        n_state = ST_LEGAL;
                    end else begin
                        n_idx   = '0;
                        n_state = ST_CHK_RD;
                    end
                end
            end
            ST_UNDO: begin
                n_mask      = r_mask & ~(MASK_W'(1) << r_rd_data);
                n_col       = r_rd_data;
                n_cur_valid = 1'b1;
                n_state     = ST_CAND;
            end
            ST_CHK_RD: begin
                w_re       = 1'b1;
                w_raddr    = r_idx;
                n_rd_valid = r_rvalid[r_idx];
                n_state    = ST_CHK;
            end
            ST_CHK: begin
                if (w_conflict) begin
                    n_state = ST_CAND;
                end else if (r_idx == r_depth - RW'(1)) begin
                    n_state = ST_LEGAL;
                end else begin
                    n_idx   = r_idx + RW'(1);
                    n_state = ST_CHK_RD;
                end
            end
            ST_LEGAL: begin
                n_nodes = sat_inc(r_nodes);
                if (CFG_W'(r_depth) + CFG_W'(1) == r_n) begin
                    n_sol = sat_inc(r_sol);
                end else begin
                    n_mask      = r_mask | (MASK_W'(1) << r_col);
                    n_depth     = r_depth + RW'(1);
                    n_cur_valid = 1'b0;
                end
                n_state = ST_CAND;
            end
            ST_DONE: begin
                n_rvalid = '0;
                n_loaded = '0;
                if (o_result.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_depth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CAND) |-> ((r_depth >= r_p) && (CFG_W'(r_depth) < r_n)))
        else $error("search depth out of range");

    a_mask_on_descend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_LEGAL) && (CFG_W'(r_depth) + CFG_W'(1) != r_n))
        |=> r_mask[$past(r_col)])
        else $error("column not marked on descent");

    a_sol_le_nodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sol <= r_nodes)
        else $error("solution count above node count");

    a_no_load_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> !i_item.ready)
        else $error("input ready while result pending");

endmodule
`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the n-queens subtree counter: loads prefix rows,
// predicts solution and node counts with a local backtracking search and
// compares every result transfer, with random gaps and stalls on both channels
// ----------------------------------------------------------------------------
module tb;
    import nqsc_pkg::*;

    localparam int MAX_ROWS       = 32;
    localparam int RANDOM_ROWS    = 45;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 600000;

    typedef struct packed {
        logic [CNT_W-1:0] solutions;
        logic [CNT_W-1:0] nodes;
    } t_count_pair;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]  i_cfg_data;

    nqsc_in_if  in_ch ();
    nqsc_out_if out_ch ();

    nqueens_subtree_counter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (in_ch),
        .o_result   (out_ch)
    );

    // local copy of the block state
    logic [CFG_W-1:0] cfg_board;
    logic [CFG_W-1:0] cfg_depth;
    logic [COL_W-1:0] prefix_cols [MAX_ROWS];
    logic             prefix_has  [MAX_ROWS];
    int unsigned      rows_loaded;

    t_count_pair expected_counts [$];
    int          errors;
    int          rows_sent;
    int          quiet_cycles;
    int          stall_left;
    logic        steady;

    always #5 i_clk = ~i_clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void clear_prefix();
        for (int i = 0; i < MAX_ROWS; i++) begin
            prefix_cols[i] = '0;
            prefix_has[i]  = 1'b0;
        end
        rows_loaded = 0;
    endfunction

    // depth-first search below the loaded prefix
    function automatic t_count_pair count_subtree(logic [MASK_W-1:0] used);
        int unsigned n, p, d, c, other, span;
        int unsigned cols [MAX_ROWS];
        bit          occ  [MAX_ROWS];
        logic [MASK_W-1:0] mask;
        bit          ok, done;
        t_count_pair res;
        res = '0;
        n = cfg_board;
        p = cfg_depth;
        if (n > MAX_ROWS) n = MAX_ROWS;
        if (p >= n) return res;
        for (int i = 0; i < MAX_ROWS; i++) begin
            cols[i] = (i < p) ? prefix_cols[i] : 0;
            occ[i]  = (i < p) ? prefix_has[i] : 1'b0;
        end
        mask = used;
        d = p;
        done = 1'b0;
        while (!done) begin
            c = occ[d] ? cols[d] + 1 : 0;
            if (c >= n) begin
                occ[d]  = 1'b0;
                cols[d] = 0;
                if (d == p) begin
                    done = 1'b1;
                end else begin
                    d = d - 1;
                    mask[cols[d] % 32] = 1'b0;
                end
            end else begin
                cols[d] = c;
                occ[d]  = 1'b1;
                if (!mask[c]) begin
                    ok = 1'b1;
                    for (int i = 0; i < d; i++) begin
                        if (occ[i]) begin
                            other = cols[i];
                            span  = d - i;
                            if (other == c || other + span == c || c + span == other) ok = 1'b0;
                        end
                    end
                    if (ok) begin
                        if (res.nodes != '1) res.nodes = res.nodes + 1;
                        if (d + 1 == n) begin
                            if (res.solutions != '1) res.solutions = res.solutions + 1;
                        end else begin
                            mask[c] = 1'b1;
                            d = d + 1;
                        end
                    end
                end
            end
        end
        return res;
    endfunction

    function automatic void take_row(logic [COL_W-1:0] col, logic present,
                                     logic [MASK_W-1:0] used, logic last);
        if (rows_loaded < MAX_ROWS) begin
            prefix_cols[rows_loaded] = present ? col : '0;
            prefix_has[rows_loaded]  = present;
            rows_loaded++;
        end
        if (last) begin
            expected_counts.push_back(count_subtree(used));
            clear_prefix();
        end
    endfunction

    task automatic send_row(input logic [COL_W-1:0] col, input logic present,
                            input logic [MASK_W-1:0] used, input logic last);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.prefix_column  <= col;
        in_ch.column_present <= present;
        in_ch.used_columns   <= used;
        in_ch.last_item      <= last;
        do @(posedge i_clk); while (!(in_ch.valid === 1'b1 && in_ch.ready === 1'b1));
        take_row(col, present, used, last);
        rows_sent++;
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (expected_counts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input int board, input int depth);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_BOARD_SIZE;
        i_cfg_data <= board[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_idx  <= CFG_PREFIX_DEPTH;
        i_cfg_data <= depth[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_board = board[CFG_W-1:0];
        cfg_depth = depth[CFG_W-1:0];
    endtask

    // one prefix of random rows ending with the last item
    task automatic send_prefix(input int len);
        int n;
        logic [COL_W-1:0]  col;
        logic              present;
        logic [MASK_W-1:0] mask;
        n = (cfg_board > MAX_ROWS) ? MAX_ROWS : cfg_board;
        mask = '0;
        for (int k = 0; k < len; k++) begin
            if (n > 0 && $urandom_range(0, 3) != 0) col = COL_W'($urandom_range(0, n - 1));
            else col = COL_W'($urandom_range(0, 31));
            present = ($urandom_range(0, 6) != 0);
            if (present) mask[col] = 1'b1;
            if (k == len - 1)
                send_row(col, present, ($urandom_range(0, 2) == 0) ? $urandom : mask, 1'b1);
            else
                send_row(col, present, $urandom, 1'b0);
        end
    endtask

    task automatic test_reset_defaults();
        send_row(5'd3, 1'b1, 32'hFFFF_FFF0, 1'b1);
        wait_idle();
    endtask

    task automatic test_small_boards();
        int sizes [5] = '{4, 0, 1, 2, 3};
        foreach (sizes[i]) begin
            set_config(sizes[i], 0);
            send_row(5'd0, 1'b0, 32'h0, 1'b1);
            wait_idle();
        end
        set_config(6, 0);
        send_row(5'd31, 1'b1, 32'h0, 1'b1);
        wait_idle();
    endtask

    task automatic test_prefix_too_deep();
        set_config(5, 5);
        send_row(5'd1, 1'b1, 32'h0, 1'b0);
        send_row(5'd3, 1'b1, 32'h0, 1'b1);
        wait_idle();
        set_config(63, 32);
        send_row(5'd7, 1'b1, 32'h0, 1'b1);
        wait_idle();
    endtask

    task automatic test_prefix_rows();
        // off-board column, empty row, and a row loaded past the prefix depth
        set_config(5, 2);
        send_row(5'd6, 1'b1, 32'h0, 1'b0);
        send_row(5'd20, 1'b0, 32'hFFFF_FFFF, 1'b0);
        send_row(5'd2, 1'b1, 32'h8000_0000, 1'b1);
        wait_idle();
        set_config(6, 1);
        send_row(5'd0, 1'b0, 32'h0, 1'b1);
        wait_idle();
    endtask

    task automatic test_oversized_board();
        set_config(63, 31);
        send_row(5'd5, 1'b1, 32'h0, 1'b0);
        send_row(5'd17, 1'b1, 32'hFFFF_FFFF, 1'b0);
        send_row(5'd0, 1'b0, 32'h0001_0040, 1'b1);
        wait_idle();
        set_config(32, 30);
        send_row(5'd31, 1'b1, 32'h0, 1'b0);
        send_row(5'd12, 1'b1, 32'h0, 1'b0);
        send_row(5'd28, 1'b1, 32'hAAAA_5555, 1'b1);
        wait_idle();
    endtask

    task automatic test_full_prefix();
        // more rows than the store holds, the extra ones are dropped
        set_config(32, 31);
        send_prefix(34);
        wait_idle();
    endtask

    task automatic test_random();
        int start, pick, board, n, depth, seqs;
        start = rows_sent;
        while (rows_sent < start + RANDOM_ROWS) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                board = $urandom_range(0, 6);
                depth = $urandom_range(0, board + 1);
            end else if (pick < 8) begin
                board = $urandom_range(7, 8);
                depth = $urandom_range(board - 4, board);
            end else begin
                board = $urandom_range(9, 63);
                n = (board > MAX_ROWS) ? MAX_ROWS : board;
                depth = $urandom_range(n - 2, n);
            end
            set_config(board, depth);
            steady = ($urandom_range(0, 3) == 0);
            seqs = $urandom_range(1, 3);
            for (int s = 0; s < seqs; s++)
                send_prefix($urandom_range(1, ((depth > 6) ? 6 : depth) + 1));
            wait_idle();
            steady = 1'b0;
        end
    endtask

    // result side: random stalls on ready
    always @(posedge i_clk) begin
        if (!i_rst_n || steady) begin
            out_ch.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            out_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 99) < 20) begin
            stall_left = gap_len();
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_result
        t_count_pair want;
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (expected_counts.size() == 0) begin
                $display("%0t: unexpected result, solutions %0d nodes %0d", $time,
                         out_ch.solution_count, out_ch.visited_nodes);
                errors++;
            end else begin
                want = expected_counts.pop_front();
                if (out_ch.solution_count !== want.solutions) begin
                    $display("%0t: solution_count expected %0d actual %0d", $time,
                             want.solutions, out_ch.solution_count);
                    errors++;
                end
                if (out_ch.visited_nodes !== want.nodes) begin
                    $display("%0t: visited_nodes expected %0d actual %0d", $time,
                             want.nodes, out_ch.visited_nodes);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
            (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) || i_cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial begin
        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = CFG_BOARD_SIZE;
        i_cfg_data           = '0;
        in_ch.valid          = 1'b0;
        in_ch.prefix_column  = '0;
        in_ch.column_present = 1'b0;
        in_ch.used_columns   = '0;
        in_ch.last_item      = 1'b0;
        out_ch.ready         = 1'b0;
        errors       = 0;
        rows_sent    = 0;
        quiet_cycles = 0;
        stall_left   = 0;
        steady       = 1'b0;
        cfg_board    = BOARD_SIZE_RST;
        cfg_depth    = PREFIX_DEPTH_RST;
        clear_prefix();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_small_boards();
        test_prefix_too_deep();
        test_prefix_rows();
        test_oversized_board();
        test_full_prefix();
        test_random();

        wait_idle();
        repeat (20) @(posedge i_clk);
        errors = errors + expected_counts.size();
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
